### rtl/core/ipma_pkg.sv
`default_nettype none

package ipma_pkg;

   // Field widths of the input word, the result word and the parser's counters
   localparam int unsigned DataWidth  = 8;
   localparam int unsigned ItemWidth  = 32;
   localparam int unsigned IndexWidth = 15;
   localparam int unsigned StatusWidth = 2;
   localparam int unsigned CountWidth = 32;
   localparam int unsigned AssocWidth = 8;
   localparam int unsigned PosWidth   = 2;

   // Parse phase of the box body
   typedef enum logic [2:0] {
      PH_VERSION = 3'd0,
      PH_FLAGS   = 3'd1,
      PH_COUNT   = 3'd2,
      PH_ITEM    = 3'd3,
      PH_ACOUNT  = 3'd4,
      PH_INDEX   = 3'd5,
      PH_DONE    = 3'd6
   } phase_type;

   // Status reported with a result word
   typedef enum logic [StatusWidth-1:0] {
      ST_PARSING   = 2'd0,
      ST_COMPLETE  = 2'd1,
      ST_TRUNCATED = 2'd2
   } status_type;

   // Byte positions inside multi-byte fields
   localparam logic [PosWidth-1:0] PosFirst     = 2'd0;
   localparam logic [PosWidth-1:0] PosSecond    = 2'd1;
   localparam logic [PosWidth-1:0] PosFlagsLast = 2'd2;
   localparam logic [PosWidth-1:0] PosWordLast  = 2'd3;

endpackage

`default_nettype wire

### rtl/core/ipma_if.sv
`default_nettype none

// Byte stream channel into the parser
interface ipma_req_if import ipma_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [DataWidth-1:0] data_byte;
   logic                 box_end;

   modport source (output valid, output data_byte, output box_end, input ready);
   modport sink   (input valid, input data_byte, input box_end, output ready);
endinterface

// Association result channel out of the parser
interface ipma_rsp_if import ipma_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   assoc_valid;
   logic [ItemWidth-1:0]   item_id;
   logic [IndexWidth-1:0]  property_index;
   logic                   essential;
   logic                   entry_last;
   logic [StatusWidth-1:0] status;

   modport source (output valid, output assoc_valid, output item_id,
                   output property_index, output essential, output entry_last,
                   output status, input ready);
   modport sink   (input valid, input assoc_valid, input item_id,
                   input property_index, input essential, input entry_last,
                   input status, output ready);
endinterface

`default_nettype wire

### rtl/core/ipma_box_parser.sv
// Item-property-association box parser.
// req: one word per byte of the box body, data_byte in big-endian order, box_end
//   high on the final byte of the body.
// rsp: at most one word per accepted byte. A word carries an association
//   (assoc_valid high, item id, property index, essential, entry_last) when a
//   property index completes, and carries the final status (complete or
//   truncated) on the byte flagged with box_end. Other bytes give no word.
// Output: the result word is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless rsp stalls; the field parser updates its state in the
//   same cycle the byte is taken and the result sits in one output register.
// Stall: while rsp is held off with a word pending, req.ready drops; it stays
//   high when the pending word is taken in the same cycle.
// Reset: synchronous, active high; parser returns to the version byte and the
//   output register empties. After each box_end byte the parser returns to the
//   same state, ready for the next box. Bytes after the last entry are dropped.
`default_nettype none

module ipma_box_parser import ipma_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   ipma_req_if.sink     req,
   ipma_rsp_if.source   rsp
);

   // Parser state
   phase_type             phase_ff, phase_in;
   logic [PosWidth-1:0]   byte_count_ff, byte_count_in;
   logic                  wide_item_ids_ff, wide_item_ids_in;
   logic                  wide_indices_ff, wide_indices_in;
   logic [CountWidth-1:0] entries_left_ff, entries_left_in;
   logic [ItemWidth-1:0]  current_item_ff, current_item_in;
   logic [AssocWidth-1:0] assocs_left_ff, assocs_left_in;
   logic [DataWidth-1:0]  index_high_ff, index_high_in;

   // Output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   assoc_valid_ff;
   logic [ItemWidth-1:0]   item_id_ff;
   logic [IndexWidth-1:0]  property_index_ff;
   logic                   essential_ff;
   logic                   entry_last_ff;
   status_type             status_ff;

   // Per-byte decode
   logic                   accept;
   logic                   have_assoc;
   logic                   assoc_last;
   logic                   assoc_essential;
   logic [IndexWidth-1:0]  assoc_index;
   status_type             status_now;
   logic [AssocWidth-1:0]  assocs_dec;
   logic [CountWidth-1:0]  entries_dec;

   assign req.ready = !reset && (!rsp_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;

   assign assocs_dec  = assocs_left_ff - AssocWidth'(1);
   assign entries_dec = entries_left_ff - CountWidth'(1);

   // Next state of the field parser
   always_comb begin
      phase_in         = phase_ff;
      byte_count_in    = byte_count_ff;
      wide_item_ids_in = wide_item_ids_ff;
      wide_indices_in  = wide_indices_ff;
      entries_left_in  = entries_left_ff;
      current_item_in  = current_item_ff;
      assocs_left_in   = assocs_left_ff;
      index_high_in    = index_high_ff;
      unique case (phase_ff)
         PH_VERSION: begin
            wide_item_ids_in = (req.data_byte != '0);
            phase_in         = PH_FLAGS;
            byte_count_in    = PosFirst;
         end
         PH_FLAGS: begin
            if (byte_count_ff == PosFlagsLast) begin
               wide_indices_in = req.data_byte[0];
               phase_in        = PH_COUNT;
               byte_count_in   = PosFirst;
               entries_left_in = '0;
            end else begin
               byte_count_in = byte_count_ff + PosWidth'(1);
            end
         end
         PH_COUNT: begin
            entries_left_in = {entries_left_ff[CountWidth-DataWidth-1:0], req.data_byte};
            if (byte_count_ff == PosWordLast) begin
               byte_count_in = PosFirst;
               phase_in      = (entries_left_in == '0) ? PH_DONE : PH_ITEM;
            end else begin
               byte_count_in = byte_count_ff + PosWidth'(1);
            end
         end
         PH_ITEM: begin
            if (byte_count_ff == PosFirst) begin
               current_item_in = ItemWidth'(req.data_byte);
            end else begin
               current_item_in = {current_item_ff[ItemWidth-DataWidth-1:0], req.data_byte};
            end
            if (byte_count_ff == (wide_item_ids_ff ? PosWordLast : PosSecond)) begin
               byte_count_in = PosFirst;
               phase_in      = PH_ACOUNT;
            end else begin
               byte_count_in = byte_count_ff + PosWidth'(1);
            end
         end
         PH_ACOUNT: begin
            assocs_left_in = req.data_byte;
            byte_count_in  = PosFirst;
            if (req.data_byte == '0) begin
               entries_left_in = entries_dec;
               phase_in        = (entries_dec == '0) ? PH_DONE : PH_ITEM;
            end else begin
               phase_in = PH_INDEX;
            end
         end
         PH_INDEX: begin
            if (wide_indices_ff && byte_count_ff == PosFirst) begin
               index_high_in = req.data_byte;
               byte_count_in = PosSecond;
            end else begin
               byte_count_in  = PosFirst;
               assocs_left_in = assocs_dec;
               if (assocs_dec == '0) begin
                  entries_left_in = entries_dec;
                  phase_in        = (entries_dec == '0) ? PH_DONE : PH_ITEM;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Result fields for the byte at the input
   always_comb begin
      have_assoc = (phase_ff == PH_INDEX) &&
                   !(wide_indices_ff && byte_count_ff == PosFirst);
      assoc_last = have_assoc && (assocs_dec == '0);
      if (wide_indices_ff) begin
         assoc_essential = index_high_ff[DataWidth-1];
         assoc_index     = {index_high_ff[DataWidth-2:0], req.data_byte};
      end else begin
         assoc_essential = req.data_byte[DataWidth-1];
         assoc_index     = IndexWidth'(req.data_byte[DataWidth-2:0]);
      end
      // Box may end between entries; anything else short is truncated
      if (!req.box_end) begin
         status_now = ST_PARSING;
      end else if (phase_in == PH_DONE || phase_in == PH_ITEM && byte_count_in == PosFirst ||
                   phase_in == phase_type'(3'd7)) begin
         status_now = ST_COMPLETE;
      end else begin
         status_now = ST_TRUNCATED;
      end
   end

   // Output word valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = have_assoc || req.box_end;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset || (accept && req.box_end)) begin
         phase_ff         <= PH_VERSION;
         byte_count_ff    <= PosFirst;
         wide_item_ids_ff <= 1'b0;
         wide_indices_ff  <= 1'b0;
         entries_left_ff  <= '0;
         current_item_ff  <= '0;
         assocs_left_ff   <= '0;
         index_high_ff    <= '0;
      end else if (accept) begin
         phase_ff         <= phase_in;
         byte_count_ff    <= byte_count_in;
         wide_item_ids_ff <= wide_item_ids_in;
         wide_indices_ff  <= wide_indices_in;
         entries_left_ff  <= entries_left_in;
         current_item_ff  <= current_item_in;
         assocs_left_ff   <= assocs_left_in;
         index_high_ff    <= index_high_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload; zero fields when no association completes
   always_ff @(posedge clock) begin
      if (accept) begin
         assoc_valid_ff    <= have_assoc;
         item_id_ff        <= have_assoc ? current_item_ff : '0;
         property_index_ff <= have_assoc ? assoc_index : '0;
         essential_ff      <= have_assoc && assoc_essential;
         entry_last_ff     <= assoc_last;
         status_ff         <= status_now;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.assoc_valid    = assoc_valid_ff;
   assign rsp.item_id        = item_id_ff;
   assign rsp.property_index = property_index_ff;
   assign rsp.essential      = essential_ff;
   assign rsp.entry_last     = entry_last_ff;
   assign rsp.status         = status_ff;

`ifndef SYNTH
   // Parser is back at the version byte after a box ends
   a_restart_after_end: assert property (@(posedge clock) disable iff (reset)
      accept && req.box_end |=> phase_ff == PH_VERSION && byte_count_ff == PosFirst)
      else $error("parser did not restart after box end");

   // A word without an association only reports the end of a box
   a_status_only_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !assoc_valid_ff |-> status_ff != ST_PARSING)
      else $error("empty result word without final status");

   // Entry end only marks a real association
   a_entry_last_assoc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && entry_last_ff |-> assoc_valid_ff)
      else $error("entry_last without association");

   // Index bytes never run past the second byte
   a_index_position: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_INDEX |-> byte_count_ff == PosFirst || byte_count_ff == PosSecond)
      else $error("index byte position out of range");
`endif

endmodule

`default_nettype wire
